>>> rtl/csc_pkg.sv
// csc_pkg: shared types and codes for the CSR structure checker.
// Used by csr_structure_checker, csc_check and csc_checker; no dependencies.
`default_nettype none

package csc_pkg;

  // Width of the configuration registers and of the held indices
  localparam int unsigned REG_W = 31;
  localparam int unsigned INDEX_WIDTH_DEFAULT = 31;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ROW_COUNT     = 2'd0,
    REG_COL_COUNT     = 2'd1,
    REG_NONZERO_COUNT = 2'd2,
    REG_INDEX_BASE    = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_POINTER = 2'd0,
    CMD_COLUMN  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_FINE     = 2'd0,
    STAT_COMPLETE = 2'd1,
    STAT_INVALID  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_FALL    = 3'd1,
    ERR_LONG    = 3'd2,
    ERR_RISE    = 3'd3,
    ERR_OUTSIDE = 3'd4,
    ERR_TOTAL   = 3'd5,
    ERR_SEQ     = 3'd6
  } err_t;

  // Walk through the stream, one-hot
  typedef enum logic [3:0] {
    PH_FIRST  = 4'b0001,
    PH_ROWEND = 4'b0010,
    PH_INROW  = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [REG_W-1:0] row_count;
    logic [REG_W-1:0] col_count;
    logic [REG_W-1:0] nonzero_count;
    logic             index_base;
  } cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic [REG_W-1:0] rows_done;
    logic [REG_W-1:0] previous_pointer;
    logic [REG_W-1:0] columns_left;
    logic [REG_W-1:0] previous_column;
    logic             column_seen;
    err_t             sticky_error;
  } state_t;

  localparam state_t STATE_CLEAR = '{
    phase:            PH_FIRST,
    rows_done:        '0,
    previous_pointer: '0,
    columns_left:     '0,
    previous_column:  '0,
    column_seen:      1'b0,
    sticky_error:     ERR_NONE
  };

endpackage

`default_nettype wire

>>> rtl/csr_structure_checker.sv
// csr_structure_checker: top level of the CSR structure checker.
// Depends on csc_pkg and csc_check.
//
//   Channel  | Handshake           | Payload
//   ---------+---------------------+------------------------------------
//   item     | item_valid/stall    | command, index_value
//   result   | result_valid/stall  | status, error_kind
//   cfg      | cfg_valid/ready     | cfg_index, cfg_data (ready always high)
//
// One request per cycle, sustained, while the result side is not stalled. The
// request lands in the input register, then one pass of csc_check updates the
// checker state and loads the result register; the state loop through
// csc_check is what sets that rate.
// rst (synchronous) clears configuration, checker state and both valids.
// A stalled result holds the result register; the input register still
// takes a request while it is empty, and item_stall rises only once both
// registers are full.
`default_nettype none

module csr_structure_checker #(
  parameter int unsigned INDEX_WIDTH = csc_pkg::INDEX_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [1:0]                 command,
  input  logic [csc_pkg::REG_W-1:0]  index_value,
  // result channel
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [1:0]                 status,
  output logic [2:0]                 error_kind,
  // configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [csc_pkg::REG_W-1:0]  cfg_data
);

  // only the low INDEX_WIDTH bits of an index take part, capped at the port
  localparam int unsigned VW = (INDEX_WIDTH < csc_pkg::REG_W) ? INDEX_WIDTH
                                                              : csc_pkg::REG_W;

  csc_pkg::cfg_t     cfg;
  csc_pkg::state_t   state;
  csc_pkg::state_t   state_next;
  csc_pkg::status_t  res_status;
  csc_pkg::err_t     res_error;

  // input register
  logic              hold_valid;
  logic [1:0]        hold_cmd;
  logic [VW-1:0]     hold_value;

  logic              advance;
  logic              item_take;

  assign cfg_ready  = 1'b1;
  assign advance    = !result_valid || !result_stall;
  assign item_stall = hold_valid && !advance;
  assign item_take  = item_valid && !item_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (csc_pkg::reg_index_t'(cfg_index))
        csc_pkg::REG_ROW_COUNT:     cfg.row_count     <= cfg_data;
        csc_pkg::REG_COL_COUNT:     cfg.col_count     <= cfg_data;
        csc_pkg::REG_NONZERO_COUNT: cfg.nonzero_count <= cfg_data;
        csc_pkg::REG_INDEX_BASE:    cfg.index_base    <= cfg_data[0];
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      hold_cmd   <= command;
      hold_value <= index_value[VW-1:0];
    end
  end

  csc_check #(
    .VALUE_WIDTH (VW)
  ) u_check (
    .st         (state),
    .cfg        (cfg),
    .command    (hold_cmd),
    .value      (hold_value),
    .st_next    (state_next),
    .status     (res_status),
    .error_kind (res_error)
  );

  // checker state and result register move together
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= csc_pkg::STATE_CLEAR;
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= hold_valid;
      if (hold_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_valid) begin
      status     <= res_status;
      error_kind <= res_error;
    end
  end

endmodule

`default_nettype wire

>>> rtl/csc_check.sv
// csc_check: combinational rule check and next-state logic for one request.
// Depends on csc_pkg (state, config and code types).
`default_nettype none

module csc_check #(
  parameter int unsigned VALUE_WIDTH = csc_pkg::REG_W
) (
  input  csc_pkg::state_t         st,
  input  csc_pkg::cfg_t           cfg,
  input  logic [1:0]              command,
  input  logic [VALUE_WIDTH-1:0]  value,
  output csc_pkg::state_t         st_next,
  output csc_pkg::status_t        status,
  output csc_pkg::err_t           error_kind
);

  csc_pkg::cmd_t                 cmd;
  logic [csc_pkg::REG_W-1:0]     v;
  logic [csc_pkg::REG_W-1:0]     base_ext;
  logic [csc_pkg::REG_W-1:0]     row_diff;
  logic [csc_pkg::REG_W-1:0]     rows_inc;
  logic [csc_pkg::REG_W-1:0]     cols_dec;
  logic [csc_pkg::REG_W-1:0]     comp_rows;
  logic [csc_pkg::REG_W-1:0]     comp_ptr;
  logic                          ptr_fall;
  logic                          row_long;
  logic                          col_rise_bad;
  logic                          col_out;
  logic                          rows_reached;
  logic                          total_ok;

  assign cmd      = csc_pkg::cmd_t'(command);
  assign v        = (csc_pkg::REG_W)'(value);
  assign base_ext = (csc_pkg::REG_W)'(cfg.index_base);
  assign row_diff = v - st.previous_pointer;
  assign rows_inc = st.rows_done + 1'b1;
  assign cols_dec = st.columns_left - 1'b1;

  assign ptr_fall     = v < st.previous_pointer;
  assign row_long     = row_diff > cfg.col_count;
  assign col_rise_bad = st.column_seen && (v <= st.previous_column);
  assign col_out      = (v < base_ext) || ((v - base_ext) >= cfg.col_count);

  // Completion check: first pointer uses the current row count, a finished
  // row the incremented one; the last column closes on the held pointer.
  assign comp_rows    = (st.phase == csc_pkg::PH_FIRST) ? st.rows_done : rows_inc;
  assign comp_ptr     = (cmd == csc_pkg::CMD_COLUMN) ? st.previous_pointer : v;
  assign rows_reached = comp_rows >= cfg.row_count;
  assign total_ok     = {1'b0, comp_ptr} ==
                        ({1'b0, cfg.nonzero_count} + (csc_pkg::REG_W + 1)'(cfg.index_base));

  always_comb begin
    st_next = st;
    if (cmd == csc_pkg::CMD_RESTART) begin
      st_next = csc_pkg::STATE_CLEAR;
    end else if (st.sticky_error == csc_pkg::ERR_NONE) begin
      priority if (cmd == csc_pkg::CMD_UNUSED || st.phase == csc_pkg::PH_DONE) begin
        st_next.sticky_error = csc_pkg::ERR_SEQ;
      end else if (cmd == csc_pkg::CMD_POINTER) begin
        unique case (st.phase)
          csc_pkg::PH_FIRST: begin
            st_next.previous_pointer = v;
            if (!rows_reached)  st_next.phase = csc_pkg::PH_ROWEND;
            else if (total_ok)  st_next.phase = csc_pkg::PH_DONE;
            else                st_next.sticky_error = csc_pkg::ERR_TOTAL;
          end
          csc_pkg::PH_ROWEND: begin
            priority if (ptr_fall) begin
              st_next.sticky_error = csc_pkg::ERR_FALL;
            end else if (row_long) begin
              st_next.sticky_error = csc_pkg::ERR_LONG;
            end else begin
              st_next.columns_left     = row_diff;
              st_next.previous_pointer = v;
              st_next.column_seen      = 1'b0;
              st_next.previous_column  = '0;
              if (row_diff == '0) begin
                // empty row closes at once
                st_next.rows_done = rows_inc;
                if (!rows_reached)  st_next.phase = csc_pkg::PH_ROWEND;
                else if (total_ok)  st_next.phase = csc_pkg::PH_DONE;
                else                st_next.sticky_error = csc_pkg::ERR_TOTAL;
              end else begin
                st_next.phase = csc_pkg::PH_INROW;
              end
            end
          end
          default: st_next.sticky_error = csc_pkg::ERR_SEQ;
        endcase
      end else begin
        priority if (st.phase != csc_pkg::PH_INROW) begin
          st_next.sticky_error = csc_pkg::ERR_SEQ;
        end else if (col_rise_bad) begin
          st_next.sticky_error = csc_pkg::ERR_RISE;
        end else if (col_out) begin
          st_next.sticky_error = csc_pkg::ERR_OUTSIDE;
        end else begin
          st_next.previous_column = v;
          st_next.column_seen     = 1'b1;
          st_next.columns_left    = cols_dec;
          if (cols_dec == '0) begin
            st_next.rows_done = rows_inc;
            if (!rows_reached)  st_next.phase = csc_pkg::PH_ROWEND;
            else if (total_ok)  st_next.phase = csc_pkg::PH_DONE;
            else                st_next.sticky_error = csc_pkg::ERR_TOTAL;
          end
        end
      end
    end
  end

  always_comb begin
    if (st_next.sticky_error != csc_pkg::ERR_NONE) begin
      status     = csc_pkg::STAT_INVALID;
      error_kind = st_next.sticky_error;
    end else begin
      status     = (st_next.phase == csc_pkg::PH_DONE) ? csc_pkg::STAT_COMPLETE
                                                        : csc_pkg::STAT_FINE;
      error_kind = csc_pkg::ERR_NONE;
    end
  end

endmodule

`default_nettype wire

>>> rtl/csc_checker.sv
// csc_checker: port-level assertions for csr_structure_checker, with bind.
// Depends on csc_pkg (status and error codes).
`default_nettype none

module csc_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  status,
  input logic [2:0]  error_kind
);

  // an invalid result always names its error
  a_invalid_has_error : assert property (@(posedge clk) disable iff (rst)
    result_valid && status == csc_pkg::STAT_INVALID |-> error_kind != csc_pkg::ERR_NONE)
    else $error("invalid result without error kind");

  // fine or complete results carry no error
  a_valid_no_error : assert property (@(posedge clk) disable iff (rst)
    result_valid && status != csc_pkg::STAT_INVALID |-> error_kind == csc_pkg::ERR_NONE)
    else $error("error kind set on a non-invalid result");

  // reset empties the result register
  a_reset_clears : assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(status) && $stable(error_kind))
    else $error("stalled result changed");

endmodule

bind csr_structure_checker csc_checker u_csc_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .status       (status),
  .error_kind   (error_kind)
);

`default_nettype wire

>>> sim/testbench.sv
// testbench: self-checking bench for csr_structure_checker.
// Depends on csc_pkg and the checker RTL. Holds its own copy of the CSR rules and
// compares every result against it.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csc_pkg::*;

  localparam logic [REG_W-1:0] IDX_MAX = '1;
  // requests sent over the whole run; random streams top up to this
  localparam int REQUEST_TARGET = 1200;
  // margin for the pipe to settle after the last result
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLDOFF_CYCLES = 150;

  typedef struct {
    status_t st;
    err_t    err;
  } verdict_t;

  typedef struct {
    cmd_t             cmd;
    logic [REG_W-1:0] val;
  } request_t;

  // ---------------------------------------------------------------------------
  // Block ports; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_stall;
  logic [1:0]       command = CMD_RESTART;
  logic [REG_W-1:0] index_value = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  logic [1:0]       status;
  logic [2:0]       error_kind;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = REG_ROW_COUNT;
  logic [REG_W-1:0] cfg_data = '0;

  csr_structure_checker DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .index_value  (index_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .error_kind   (error_kind),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  verdict_t pending_verdicts[$];   // expected results, oldest first
  request_t matrix_plan[$];        // request stream of the matrix being built
  int       mismatch_count = 0;
  int       sent_requests = 0;     // requests accepted by the block so far
  int       gap_pct = 33;          // sender idle chance per cycle
  int       stall_pct = 33;        // receiver stall chance per cycle
  int       holdoffs_asked = 0;    // bumped by a test to ask for a long receiver hold-off
  int       holdoffs_served = 0;
  int       hold_left = 0;

  // Shadow copy of the registers and of the walk through the stream
  logic [REG_W-1:0] rows_reg = '0;
  logic [REG_W-1:0] cols_reg = '0;
  logic [REG_W-1:0] nnz_reg = '0;
  logic             base_reg = 1'b0;
  phase_t           walk_phase;
  logic [REG_W-1:0] rows_finished;
  logic [REG_W-1:0] row_start_ptr;
  logic [REG_W-1:0] cols_due;
  logic [REG_W-1:0] last_col;
  logic             col_seen;
  err_t             held_err;

  // ---------------------------------------------------------------------------
  // CSR rule predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_walk();
    walk_phase    = PH_FIRST;
    rows_finished = '0;
    row_start_ptr = '0;
    cols_due      = '0;
    last_col      = '0;
    col_seen      = 1'b0;
    held_err      = ERR_NONE;
  endfunction

  // Either the matrix is over (total check) or the next row end pointer is due.
  // The total is compared one bit wider: nonzero count plus base may not fit.
  function automatic void close_matrix_or_row();
    logic [REG_W:0] final_ptr;
    final_ptr = {1'b0, nnz_reg} + (REG_W+1)'(base_reg);
    if (rows_finished >= rows_reg) begin
      if ({1'b0, row_start_ptr} != final_ptr) held_err = ERR_TOTAL;
      else walk_phase = PH_DONE;
    end else begin
      walk_phase = PH_ROWEND;
    end
  endfunction

  function automatic void end_row();
    rows_finished = rows_finished + 1'b1;
    close_matrix_or_row();
  endfunction

  function automatic verdict_t apply_csr_rules(cmd_t cmd, logic [REG_W-1:0] v);
    verdict_t vd;
    if (cmd == CMD_RESTART) begin
      clear_walk();
      vd.st  = STAT_FINE;
      vd.err = ERR_NONE;
      return vd;
    end
    // once an error is held, everything but a restart is ignored
    if (held_err == ERR_NONE) begin
      if (cmd == CMD_UNUSED || walk_phase == PH_DONE) begin
        held_err = ERR_SEQ;
      end else if (cmd == CMD_POINTER) begin
        if (walk_phase == PH_FIRST) begin
          // base pointer: value taken as is
          row_start_ptr = v;
          close_matrix_or_row();
        end else if (walk_phase == PH_ROWEND) begin
          // falling is tested before length
          if (v < row_start_ptr) begin
            held_err = ERR_FALL;
          end else if (v - row_start_ptr > cols_reg) begin
            held_err = ERR_LONG;
          end else begin
            cols_due      = v - row_start_ptr;
            row_start_ptr = v;
            col_seen      = 1'b0;
            last_col      = '0;
            if (cols_due == '0) end_row();
            else walk_phase = PH_INROW;
          end
        end else begin
          held_err = ERR_SEQ;  // pointer while columns are still due
        end
      end else begin
        // rising is tested before range; below base counts as outside
        if (walk_phase != PH_INROW) begin
          held_err = ERR_SEQ;
        end else if (col_seen && v <= last_col) begin
          held_err = ERR_RISE;
        end else if (v < REG_W'(base_reg) || v - REG_W'(base_reg) >= cols_reg) begin
          held_err = ERR_OUTSIDE;
        end else begin
          last_col = v;
          col_seen = 1'b1;
          cols_due = cols_due - 1'b1;
          if (cols_due == '0) end_row();
        end
      end
    end
    if (held_err != ERR_NONE) begin
      vd.st  = STAT_INVALID;
      vd.err = held_err;
    end else if (walk_phase == PH_DONE) begin
      vd.st  = STAT_COMPLETE;
      vd.err = ERR_NONE;
    end else begin
      vd.st  = STAT_FINE;
      vd.err = ERR_NONE;
    end
    return vd;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // One request: random idle cycles first, then hold it until the edge that takes it.
  // valid is only lowered in a gap, so back-to-back requests never see a low-high
  // pair of assignments in one step.
  task automatic send_request(input cmd_t cmd, input logic [REG_W-1:0] v);
    while ($urandom_range(0, 99) < gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid  <= 1'b1;
    command     <= cmd;
    index_value <= v;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent_requests++;
    pending_verdicts.push_back(apply_csr_rules(cmd, v));
  endtask

  // Sender stops and waits until every result is in, then lets the pipe settle.
  task automatic wait_for_verdicts();
    item_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [REG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROW_COUNT:     rows_reg = data;
      REG_COL_COUNT:     cols_reg = data;
      REG_NONZERO_COUNT: nnz_reg  = data;
      REG_INDEX_BASE:    base_reg = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [REG_W-1:0] rows, input logic [REG_W-1:0] cols,
                           input logic [REG_W-1:0] nnz, input logic base);
    wait_for_verdicts();
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
    write_reg(REG_NONZERO_COUNT, nnz);
    write_reg(REG_INDEX_BASE, {{(REG_W-1){1'b0}}, base});
  endtask

  function automatic void plan_add(cmd_t cmd, logic [REG_W-1:0] v);
    request_t rq;
    rq.cmd = cmd;
    rq.val = v;
    matrix_plan.push_back(rq);
  endfunction

  // Builds a well-formed stream: base pointer, then per row its end pointer and
  // strictly rising columns inside [base, base + cols). Returns the stored count.
  task automatic build_matrix(input int rows, input logic [REG_W-1:0] cols,
                              input logic base, output int total);
    int               len;
    int               need;
    logic [REG_W-1:0] ptr;
    logic [REG_W-1:0] colv;
    logic [REG_W-1:0] spread;
    matrix_plan.delete();
    total = 0;
    ptr = REG_W'(base);
    plan_add(CMD_POINTER, ptr);
    for (int r = 0; r < rows; r++) begin
      len = $urandom_range(0, (cols < 4) ? int'(cols) : 4);
      total += len;
      ptr = ptr + REG_W'(len);
      plan_add(CMD_POINTER, ptr);
      if (cols <= 64) begin
        // pick exactly len of the cols slots, in order
        need = len;
        for (int k = 0; k < int'(cols); k++) begin
          if (need > 0 && $urandom_range(1, int'(cols) - k) <= need) begin
            colv = REG_W'(base) + REG_W'(k);
            plan_add(CMD_COLUMN, colv);
            need--;
          end
        end
      end else begin
        // wide matrix: up to five steps of an eighth each stay inside
        spread = cols >> 3;
        colv = REG_W'(base) + REG_W'($urandom_range(0, spread));
        repeat (len) begin
          plan_add(CMD_COLUMN, colv);
          colv = colv + REG_W'($urandom_range(1, spread));
        end
      end
    end
  endtask

  task automatic send_plan();
    send_request(CMD_RESTART, REG_W'($urandom));
    foreach (matrix_plan[i]) send_request(matrix_plan[i].cmd, matrix_plan[i].val);
  endtask

  // Random matrix with fresh registers; some streams get corrupted on the way.
  task automatic run_random_matrix(input bit damage);
    int               rows;
    int               total;
    int               pick;
    logic [REG_W-1:0] cols;
    logic [REG_W-1:0] nnz;
    logic [REG_W-1:0] rows_cfg;
    logic             base;
    rows = ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 12))
                                       : int'($urandom_range(0, 4));
    base = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0:       cols = IDX_MAX;
      1:       cols = REG_W'($urandom);
      default: cols = REG_W'($urandom_range(0, 6));
    endcase
    build_matrix(rows, cols, base, total);
    case ($urandom_range(0, 9))
      0:       nnz = REG_W'(total + 1);
      1:       nnz = IDX_MAX;
      2:       nnz = REG_W'($urandom);
      default: nnz = REG_W'(total);
    endcase
    // now and then a row count the stream never reaches
    rows_cfg = ($urandom_range(0, 19) == 0) ? IDX_MAX : REG_W'(rows);
    configure(rows_cfg, cols, nnz, base);
    if (damage && $urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        if (matrix_plan.size() == 0) plan_add(CMD_COLUMN, REG_W'(base));
        pick = $urandom_range(0, matrix_plan.size() - 1);
        case ($urandom_range(0, 5))
          0: matrix_plan[pick].val = REG_W'($urandom);
          1: matrix_plan[pick].val = matrix_plan[pick].val - 1'b1;
          2: matrix_plan[pick].val = matrix_plan[pick].val + 1'b1;
          3: matrix_plan[pick].cmd = cmd_t'($urandom_range(0, 3));
          4: matrix_plan.delete(pick);
          default: plan_add(cmd_t'($urandom_range(0, 3)), REG_W'($urandom_range(0, 8)));
        endcase
      end
    end
    send_plan();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a counted hold-off when a test asks for one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (holdoffs_asked != holdoffs_served) begin
      result_stall    <= 1'b1;
      hold_left       <= HOLDOFF_CYCLES;
      holdoffs_served <= holdoffs_served + 1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: values seen at the edge are the ones before it
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (!rst && result_valid === 1'b1 && result_stall == 1'b0) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d error_kind %0d",
                 $time, status, error_kind);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (status !== want.st) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.st, status);
          mismatch_count++;
        end
        if (error_kind !== want.err) begin
          $display("%0t: error_kind expected %0d, actual %0d", $time, want.err, error_kind);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Zero rows: the base pointer alone ends the matrix. Also sticky errors and
  // a request after completion.
  task automatic test_empty_matrix();
    configure('0, '0, '0, 1'b0);
    send_request(CMD_RESTART, IDX_MAX);
    send_request(CMD_POINTER, IDX_MAX);  // unchecked base, but total is off
    send_request(CMD_COLUMN, '0);        // ignored, error held
    send_request(CMD_RESTART, '0);
    send_request(CMD_POINTER, '0);       // complete at once
    send_request(CMD_POINTER, '0);       // anything after completion is out of sequence
  endtask

  // One-based matrix at full column width: empty row, extreme column, falling
  // pointer, check order of rising against range, and the unused command.
  task automatic test_row_rules();
    configure(31'd2, IDX_MAX, 31'd2, 1'b1);
    send_request(CMD_RESTART, '0);
    send_request(CMD_POINTER, 31'd1);
    send_request(CMD_POINTER, 31'd1);    // empty row
    send_request(CMD_POINTER, 31'd3);
    send_request(CMD_COLUMN, 31'd1);
    send_request(CMD_COLUMN, IDX_MAX);
    send_request(CMD_RESTART, '0);
    send_request(CMD_POINTER, 31'd5);
    send_request(CMD_POINTER, 31'd4);    // falls
    send_request(CMD_RESTART, '0);
    send_request(CMD_POINTER, 31'd1);
    send_request(CMD_POINTER, 31'd3);
    send_request(CMD_COLUMN, 31'd1);
    send_request(CMD_COLUMN, 31'd0);     // below base and not rising: rising wins
    send_request(CMD_RESTART, '0);
    send_request(CMD_UNUSED, IDX_MAX);
  endtask

  // A register changed mid-stream applies from the next request.
  task automatic test_register_change();
    configure(31'd1, 31'd1, 31'd1, 1'b0);
    send_request(CMD_RESTART, '0);
    send_request(CMD_POINTER, '0);
    wait_for_verdicts();
    write_reg(REG_COL_COUNT, '0);
    send_request(CMD_POINTER, 31'd1);    // now too long
  endtask

  // No idling on either side for a long stretch.
  task automatic test_full_rate();
    int total;
    gap_pct   = 0;
    stall_pct = 0;
    configure(31'd3, 31'd5, 31'd6, 1'b0);
    repeat (12) begin
      build_matrix(3, 31'd5, 1'b0, total);
      send_plan();
    end
    wait_for_verdicts();
    gap_pct   = 33;
    stall_pct = 33;
  endtask

  // Receiver holds off while the sender keeps offering, so the block fills up
  // and stalls its input; then the sender pauses until everything is back and sends more.
  task automatic test_backpressure();
    int total;
    configure(31'd4, 31'd6, 31'd8, 1'b1);
    holdoffs_asked++;
    repeat (8) begin
      build_matrix(4, 31'd6, 1'b1, total);
      send_plan();
    end
    wait_for_verdicts();
    repeat (4) begin
      build_matrix(4, 31'd6, 1'b1, total);
      send_plan();
    end
  endtask

  task automatic test_random_streams();
    while (sent_requests < REQUEST_TARGET) run_random_matrix(1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_walk();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_matrix();
    test_row_rules();
    test_register_change();
    test_full_rate();
    test_backpressure();
    test_random_streams();
    wait_for_verdicts();
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run
  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
